FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// Widths, register indexes and types of the peak-to-peak power meter.
// ----------------------------------------------------------------------------
package ppm_pkg;

  // Field widths of the channels and the configuration registers.
  localparam int SAMPLE_W  = 10;
  localparam int ELAPSED_W = 16;
  localparam int RMS_W     = 20;
  localparam int POWER_W   = 20;
  localparam int ENERGY_W  = 48;
  localparam int ZERO_W    = 10;
  localparam int GAIN_W    = 16;
  localparam int OFFS_W    = 10;
  localparam int FLOOR_W   = 10;
  localparam int VOLT_W    = 9;

  // Default converter resolution.
  localparam int ADC_BITS_DEF = 10;

  // Internal datapath widths. The peak-to-peak span is bounded by a 10-bit
  // sample minus a 10-bit offset on both sides, so it fits 11 bits.
  localparam int P2P_W     = 11;
  localparam int GAIN_FRAC = 8;
  localparam int CUR_W     = P2P_W + GAIN_W - GAIN_FRAC;
  localparam int DVD_W     = CUR_W + VOLT_W;
  localparam int QUO_W     = CUR_W;
  localparam int PROD_W    = QUO_W + ELAPSED_W;
  localparam int CNT_W     = $clog2(DVD_W);

  // Milliwatts to watts.
  localparam int DIV_W = 10;
  localparam logic [DIV_W:0] DIVISOR = (DIV_W + 1)'(1000);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] IDX_ZERO_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_OFFSET_ERR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_FLOOR       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_LINE_VOLTS  = 3'd4;

  // Operation codes of an input beat.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Configuration register set.
  typedef struct packed {
    logic [ZERO_W-1:0]  zero_offset;
    logic [GAIN_W-1:0]  current_gain_q8;
    logic [OFFS_W-1:0]  offset_error_ma;
    logic [FLOOR_W-1:0] floor_ma;
    logic [VOLT_W-1:0]  line_volts;
  } ppm_cfg_t;

  localparam ppm_cfg_t CFG_RESET = '{
    zero_offset:     ZERO_W'(512),
    current_gain_q8: GAIN_W'(2916),
    offset_error_ma: OFFS_W'(75),
    floor_ma:        FLOOR_W'(35),
    line_volts:      VOLT_W'(240)
  };

endpackage

FILE: rtl/ppm_if.sv
// ----------------------------------------------------------------------------
// ppm_in_if / ppm_out_if
// Valid/ready channels for sample and finish beats and for result beats.
// ----------------------------------------------------------------------------
interface ppm_in_if import ppm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [SAMPLE_W-1:0]  adc_sample;
  logic [ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, operation, adc_sample, elapsed_ms, input ready);
  modport sink   (input valid, operation, adc_sample, elapsed_ms, output ready);
endinterface

interface ppm_out_if import ppm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RMS_W-1:0]    rms_ma;
  logic [POWER_W-1:0]  power_watts;
  logic [ENERGY_W-1:0] energy_watt_ms;

  modport source (output valid, rms_ma, power_watts, energy_watt_ms, input ready);
  modport sink   (input valid, rms_ma, power_watts, energy_watt_ms, output ready);
endinterface

FILE: rtl/peak_to_peak_power_meter_unit.sv
// ----------------------------------------------------------------------------
// peak_to_peak_power_meter_unit
// Peak-to-peak current tracker with RMS, power and energy on a finish beat.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries sample beats and finish beats. A sample beat
// updates the window's largest and smallest deviation from the zero offset
// and gives no result; the unit stays ready for the next beat. A finish
// beat restarts the window and gives one result beat on the output channel
// with RMS milliamps, integer watts and the energy total.
// A finish runs through one shared shift-and-add multiplier and a
// one-bit-per-cycle divider: the gain product, then the offset and floor,
// the voltage product, the division by 1000, the elapsed-time product and
// the energy add, after which the result is registered. The input takes
// the next beat once the sequencer is back to idle, so a finish holds off
// the input until its result is registered.
// The input is ready whenever the unit is idle, also while a result waits
// in the output register; a finish that completes while the receiver is
// still stalled holds in its last step until the output register frees.
// Synchronous reset restores the register defaults, empties the window,
// clears the energy total and drops any pending result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module peak_to_peak_power_meter_unit import ppm_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ppm_in_if.sink                in_bus,
  ppm_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Deviation width: room for the 2^ADC_BITS window start and a sign.
  localparam int DEV_W       = ((ADC_BITS > SAMPLE_W) ? ADC_BITS : SAMPLE_W) + 2;
  localparam int SAMPLE_BITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam logic signed [DEV_W-1:0] MIN_RESET = DEV_W'(2 ** ADC_BITS);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_CUR  = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_MUL3 = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;

  // Control state.
  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  ppm_cfg_t                cfg_r, cfg_nxt;
  logic signed [DEV_W-1:0] max_dev_r, max_dev_nxt;
  logic signed [DEV_W-1:0] min_dev_r, min_dev_nxt;
  logic                    have_prev_r, have_prev_nxt;
  logic [ENERGY_W-1:0]     energy_r, energy_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [PROD_W-1:0]       mcand_r, mcand_nxt;
  logic [ELAPSED_W-1:0]    mplier_r, mplier_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [DVD_W-1:0]        dvd_r, dvd_nxt;
  logic [DIV_W-1:0]        rem_r, rem_nxt;
  logic [CUR_W-1:0]        cur_r, cur_nxt;
  logic [ELAPSED_W-1:0]    elapsed_r, elapsed_nxt;
  logic [RMS_W-1:0]        out_rms_r, out_rms_nxt;
  logic [POWER_W-1:0]      out_power_r, out_power_nxt;
  logic [ENERGY_W-1:0]     out_energy_r, out_energy_nxt;

  // Combinational helpers.
  logic                    in_fire;
  logic                    out_fire;
  logic                    fin_fire;
  logic                    seq_started;
  logic signed [DEV_W-1:0] dev;
  logic signed [DEV_W-1:0] diff;
  logic [P2P_W-1:0]        p2p;
  logic [PROD_W-1:0]       mul_sum;
  logic [CUR_W-1:0]        raw;
  logic [CUR_W-1:0]        cur_val;
  logic [DIV_W:0]          trial;
  logic                    quo_bit;
  logic [ENERGY_W:0]       energy_sum;
  logic [ENERGY_W-1:0]     energy_val;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_valid_r && out_bus.ready;

  assign in_bus.ready           = (state_r == ST_IDLE);
  assign out_bus.valid          = out_valid_r;
  assign out_bus.rms_ma         = out_rms_r;
  assign out_bus.power_watts    = out_power_r;
  assign out_bus.energy_watt_ms = out_energy_r;

  // Deviation of the incoming sample and the current window span.
  assign dev  = $signed(DEV_W'(in_bus.adc_sample[SAMPLE_BITS-1:0]))
              - $signed(DEV_W'(cfg_r.zero_offset));
  assign diff = max_dev_r - min_dev_r;
  assign p2p  = (diff > 0) ? diff[P2P_W-1:0] : '0;

  // One shift-and-add step of the shared multiplier.
  assign mul_sum = mplier_r[0] ? (prod_r + mcand_r) : prod_r;

  // Offset removal and floor on the truncated gain product.
  always_comb begin
    raw = prod_r[GAIN_FRAC +: CUR_W];
    if (raw < CUR_W'(cfg_r.offset_error_ma)) begin
      cur_val = '0;
    end else begin
      cur_val = raw - CUR_W'(cfg_r.offset_error_ma);
    end
    if (cur_val < CUR_W'(cfg_r.floor_ma)) begin
      cur_val = '0;
    end
  end

  // One restoring step of the division by 1000.
  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign quo_bit = (trial >= DIVISOR);

  // Saturating energy accumulation; the first finish after reset adds nothing.
  assign energy_sum = {1'b0, energy_r} + (ENERGY_W + 1)'(prod_r);
  always_comb begin
    if (!have_prev_r) begin
      energy_val = energy_r;
    end else if (energy_sum[ENERGY_W]) begin
      energy_val = '1;
    end else begin
      energy_val = energy_sum[ENERGY_W-1:0];
    end
  end

  // Next-state logic of the sequencer and the datapath.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cfg_nxt        = cfg_r;
    max_dev_nxt    = max_dev_r;
    min_dev_nxt    = min_dev_r;
    have_prev_nxt  = have_prev_r;
    energy_nxt     = energy_r;
    out_valid_nxt  = out_valid_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    prod_nxt       = prod_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    cur_nxt        = cur_r;
    elapsed_nxt    = elapsed_r;
    out_rms_nxt    = out_rms_r;
    out_power_nxt  = out_power_r;
    out_energy_nxt = out_energy_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    // Register writes; unknown indexes are dropped.
    if (cfg_we) begin
      unique case (cfg_index)
        IDX_ZERO_OFFSET: cfg_nxt.zero_offset     = cfg_data[ZERO_W-1:0];
        IDX_GAIN:        cfg_nxt.current_gain_q8 = cfg_data[GAIN_W-1:0];
        IDX_OFFSET_ERR:  cfg_nxt.offset_error_ma = cfg_data[OFFS_W-1:0];
        IDX_FLOOR:       cfg_nxt.floor_ma        = cfg_data[FLOOR_W-1:0];
        IDX_LINE_VOLTS:  cfg_nxt.line_volts      = cfg_data[VOLT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_bus.operation == OP_SAMPLE) begin
            if (dev > max_dev_r) begin
              max_dev_nxt = dev;
            end
            if (dev < min_dev_r) begin
              min_dev_nxt = dev;
            end
          end else begin
            mcand_nxt   = PROD_W'(cfg_r.current_gain_q8);
            mplier_nxt  = ELAPSED_W'(p2p);
            prod_nxt    = '0;
            cnt_nxt     = CNT_W'(P2P_W - 1);
            elapsed_nxt = in_bus.elapsed_ms;
            max_dev_nxt = '0;
            min_dev_nxt = MIN_RESET;
            state_nxt   = ST_MUL1;
          end
        end
      end

      ST_MUL1: begin
        prod_nxt   = mul_sum;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_CUR;
        end
      end

      ST_CUR: begin
        cur_nxt    = cur_val;
        mcand_nxt  = PROD_W'(cur_val);
        mplier_nxt = ELAPSED_W'(cfg_r.line_volts);
        prod_nxt   = '0;
        cnt_nxt    = CNT_W'(VOLT_W - 1);
        state_nxt  = ST_MUL2;
      end

      ST_MUL2: begin
        prod_nxt   = mul_sum;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          dvd_nxt   = mul_sum[DVD_W-1:0];
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(DVD_W - 1);
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        rem_nxt = quo_bit ? DIV_W'(trial - DIVISOR) : trial[DIV_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], quo_bit};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          // The quotient now fills the dividend register.
          mcand_nxt  = PROD_W'(dvd_nxt[QUO_W-1:0]);
          mplier_nxt = elapsed_r;
          prod_nxt   = '0;
          cnt_nxt    = CNT_W'(ELAPSED_W - 1);
          state_nxt  = ST_MUL3;
        end
      end

      ST_MUL3: begin
        prod_nxt   = mul_sum;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_ACC;
        end
      end

      ST_ACC: begin
        if (!out_valid_r || out_bus.ready) begin
          energy_nxt     = energy_val;
          have_prev_nxt  = 1'b1;
          out_rms_nxt    = RMS_W'(cur_r);
          out_power_nxt  = POWER_W'(dvd_r[QUO_W-1:0]);
          out_energy_nxt = energy_val;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cfg_r       <= CFG_RESET;
      max_dev_r   <= '0;
      min_dev_r   <= MIN_RESET;
      have_prev_r <= 1'b0;
      energy_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cfg_r       <= cfg_nxt;
      max_dev_r   <= max_dev_nxt;
      min_dev_r   <= min_dev_nxt;
      have_prev_r <= have_prev_nxt;
      energy_r    <= energy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mcand_r      <= mcand_nxt;
    mplier_r     <= mplier_nxt;
    prod_r       <= prod_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    cur_r        <= cur_nxt;
    elapsed_r    <= elapsed_nxt;
    out_rms_r    <= out_rms_nxt;
    out_power_r  <= out_power_nxt;
    out_energy_r <= out_energy_nxt;
  end

  // Conditions watched by the assertions below.
  assign fin_fire    = in_fire && (in_bus.operation == OP_FINISH);
  assign seq_started = (state_r == ST_MUL1) && (max_dev_r == '0) && (min_dev_r == MIN_RESET);

  // A finish beat starts the gain product and restarts the window.
  `ASSERT_NEXT(a_finish_starts, fin_fire, seq_started, "finish did not start the sequence")

  // The energy total only grows outside reset.
  `ASSERT_SAME(a_energy_monotonic, $past(rst_n), energy_r >= $past(energy_r), "energy fell")

  // A result is only raised from the accumulate step.
  `ASSERT_SAME(a_result_src, $rose(out_valid_r), $past(state_r) == ST_ACC, "stray result")

  // The division remainder stays below the divisor.
  `ASSERT_SAME(a_rem_bound, state_r == ST_DIV, {1'b0, rem_r} < DIVISOR, "remainder too large")

endmodule

FILE: tb/tb_peak_to_peak_power_meter_unit.sv
// ----------------------------------------------------------------------------
// tb_peak_to_peak_power_meter_unit
// Self-checking bench for the peak-to-peak current and energy meter.
// Sample and finish beats go into the input channel. A local predictor
// follows the deviation window, the RMS current, the integer watts and the
// saturating energy total, and queues one expected reading per finish.
// Every result beat is checked field by field against the oldest reading.
// Directed windows come first, then random windows under changing register
// settings with random idling on both channels, and last a back-to-back run
// of full-scale windows without any idling.
// ----------------------------------------------------------------------------
module tb_peak_to_peak_power_meter_unit import ppm_pkg::*; ();

  localparam int SETTLE_CYCLES      = 4;
  localparam int TAIL_CYCLES        = 80;
  localparam int RANDOM_ITEMS       = 660;
  localparam int FULL_SCALE_WINDOWS = 10;

  localparam longint unsigned RMS_MAX    = (64'd1 << RMS_W) - 1;
  localparam longint unsigned POWER_MAX  = (64'd1 << POWER_W) - 1;
  localparam longint unsigned ENERGY_MAX = (64'd1 << ENERGY_W) - 1;

  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX  = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [ZERO_W-1:0]    ZERO_MAX    = '1;
  localparam logic [GAIN_W-1:0]    GAIN_MAX    = '1;
  localparam logic [VOLT_W-1:0]    VOLT_MAX    = '1;

  // Indexes beyond the register list; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [RMS_W-1:0]    rms_ma;
    logic [POWER_W-1:0]  power_watts;
    logic [ENERGY_W-1:0] energy_watt_ms;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppm_in_if  in_bus ();
  ppm_out_if out_bus ();

  peak_to_peak_power_meter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state: register mirror, deviation window and energy total.
  ppm_cfg_t        meter_cfg;
  int              peak_hi;
  int              peak_lo;
  bit              energy_armed;
  longint unsigned energy_acc;

  reading_t readings_due[$];
  reading_t due_head;
  int       errors = 0;
  bit       idle_en;
  int       stall_left = 0;

  function automatic void restart_window();
    peak_hi = 0;
    peak_lo = 1 << ADC_BITS_DEF;
  endfunction

  function automatic void meter_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      IDX_ZERO_OFFSET: meter_cfg.zero_offset     = data[ZERO_W-1:0];
      IDX_GAIN:        meter_cfg.current_gain_q8 = data[GAIN_W-1:0];
      IDX_OFFSET_ERR:  meter_cfg.offset_error_ma = data[OFFS_W-1:0];
      IDX_FLOOR:       meter_cfg.floor_ma        = data[FLOOR_W-1:0];
      IDX_LINE_VOLTS:  meter_cfg.line_volts      = data[VOLT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void meter_sample(input logic [SAMPLE_W-1:0] smp);
    int dev;
    dev = int'(smp) - int'(meter_cfg.zero_offset);
    if (dev > peak_hi) peak_hi = dev;
    if (dev < peak_lo) peak_lo = dev;
  endfunction

  // Close the window: RMS current, watts and the energy total after it.
  function automatic reading_t meter_finish(input logic [ELAPSED_W-1:0] ms);
    int              span_signed;
    longint unsigned span;
    longint unsigned raw;
    longint unsigned cur;
    longint unsigned watts;
    longint unsigned add;
    reading_t        r;
    span_signed = peak_hi - peak_lo;
    // An empty window has a negative span, which reads as zero.
    span = (span_signed > 0) ? longint'(span_signed) : 64'd0;
    raw  = (span * meter_cfg.current_gain_q8) >> GAIN_FRAC;
    cur  = (raw < meter_cfg.offset_error_ma) ? 64'd0 : raw - meter_cfg.offset_error_ma;
    if (cur < meter_cfg.floor_ma) cur = 0;
    // Milliwatts to whole watts, truncated.
    watts = (cur * meter_cfg.line_volts) / 1000;
    if (watts > POWER_MAX) watts = POWER_MAX;
    // The first finish only starts the timebase.
    if (energy_armed) begin
      add = watts * ms;
      if (add > ENERGY_MAX - energy_acc) energy_acc = ENERGY_MAX;
      else energy_acc += add;
    end
    energy_armed = 1'b1;
    restart_window();
    r.rms_ma         = RMS_W'((cur > RMS_MAX) ? RMS_MAX : cur);
    r.power_watts    = POWER_W'(watts);
    r.energy_watt_ms = ENERGY_W'(energy_acc);
    return r;
  endfunction

  // Send one beat; the predictor follows at the edge that accepts it.
  task automatic send_beat(input logic op, input logic [SAMPLE_W-1:0] smp,
                           input logic [ELAPSED_W-1:0] ms);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.adc_sample <= smp;
    in_bus.elapsed_ms <= ms;
    do @(posedge clk); while (!in_bus.ready);
    if (op == OP_FINISH) readings_due.push_back(meter_finish(ms));
    else meter_sample(smp);
  endtask

  // Hold off the sender until every reading is back and the unit is idle.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    meter_config(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int width);
    int top;
    top = (1 << width) - 1;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(top);
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, top));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SAMPLE_MAX;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ELAPSED_MAX;
      default: return ELAPSED_W'($urandom);
    endcase
  endfunction

  // Receiver side: ready drops in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 7);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Every result beat is matched against the oldest queued reading.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got rms %0d power %0d energy %0d",
                 $time, out_bus.rms_ma, out_bus.power_watts, out_bus.energy_watt_ms);
        errors++;
      end else begin
        due_head = readings_due.pop_front();
        check_field("rms_ma", due_head.rms_ma, out_bus.rms_ma);
        check_field("power_watts", due_head.power_watts, out_bus.power_watts);
        check_field("energy_watt_ms", due_head.energy_watt_ms, out_bus.energy_watt_ms);
      end
    end
  end

  // Finishes with an empty window; the first one must add no energy.
  task automatic test_empty_window();
    send_beat(OP_FINISH, SAMPLE_MAX, ELAPSED_MAX);
    send_beat(OP_FINISH, '0, ELAPSED_MAX);
  endtask

  // Sample extremes, and windows that only go below or only above zero.
  task automatic test_deviation_extremes();
    send_beat(OP_SAMPLE, '0, ELAPSED_MAX);
    send_beat(OP_SAMPLE, SAMPLE_MAX, '0);
    send_beat(OP_FINISH, '0, ELAPSED_W'(1000));
    send_beat(OP_SAMPLE, '0, '0);
    send_beat(OP_SAMPLE, SAMPLE_W'(300), '0);
    send_beat(OP_FINISH, SAMPLE_MAX, '0);
    send_beat(OP_SAMPLE, SAMPLE_MAX, '0);
    send_beat(OP_FINISH, '0, ELAPSED_W'(123));
  endtask

  // Current below the offset error, just below the floor, and at the floor.
  task automatic test_offset_and_floor();
    wait_idle();
    write_reg(IDX_ZERO_OFFSET, CFG_DATA_W'(512));
    write_reg(IDX_GAIN, CFG_DATA_W'(256));
    write_reg(IDX_OFFSET_ERR, CFG_DATA_W'(10));
    write_reg(IDX_FLOOR, CFG_DATA_W'(20));
    send_beat(OP_SAMPLE, SAMPLE_W'(512), '0);
    send_beat(OP_SAMPLE, SAMPLE_W'(517), '0);
    send_beat(OP_FINISH, '0, ELAPSED_W'(50));
    send_beat(OP_SAMPLE, SAMPLE_W'(512), '0);
    send_beat(OP_SAMPLE, SAMPLE_W'(541), '0);
    send_beat(OP_FINISH, '0, ELAPSED_W'(50));
    send_beat(OP_SAMPLE, SAMPLE_W'(512), '0);
    send_beat(OP_SAMPLE, SAMPLE_W'(542), '0);
    send_beat(OP_FINISH, '0, ELAPSED_W'(50));
  endtask

  // Writes to indexes past the register list leave every setting alone.
  task automatic test_unknown_index();
    wait_idle();
    for (int idx = IDX_UNUSED_FIRST; idx <= IDX_UNUSED_LAST; idx++)
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    send_beat(OP_SAMPLE, SAMPLE_W'(512), '0);
    send_beat(OP_SAMPLE, SAMPLE_W'(600), '0);
    send_beat(OP_FINISH, '0, ELAPSED_W'(7));
  endtask

  // The window survives a zero offset change, giving the widest span.
  task automatic test_span_across_offset();
    wait_idle();
    write_reg(IDX_GAIN, CFG_DATA_W'(GAIN_MAX));
    write_reg(IDX_OFFSET_ERR, '0);
    write_reg(IDX_FLOOR, '0);
    write_reg(IDX_LINE_VOLTS, CFG_DATA_W'(VOLT_MAX));
    write_reg(IDX_ZERO_OFFSET, '0);
    send_beat(OP_SAMPLE, SAMPLE_MAX, '0);
    wait_idle();
    write_reg(IDX_ZERO_OFFSET, CFG_DATA_W'(ZERO_MAX));
    send_beat(OP_SAMPLE, '0, '0);
    send_beat(OP_FINISH, '0, ELAPSED_MAX);
  endtask

  // Random windows under random register settings, some of them empty.
  task automatic test_random_windows();
    int sent;
    int n_smp;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      write_reg(IDX_ZERO_OFFSET, pick_reg_value(ZERO_W));
      write_reg(IDX_GAIN, pick_reg_value(GAIN_W));
      write_reg(IDX_OFFSET_ERR, pick_reg_value(OFFS_W));
      write_reg(IDX_FLOOR, pick_reg_value(FLOOR_W));
      write_reg(IDX_LINE_VOLTS, pick_reg_value(VOLT_W));
      if ($urandom_range(0, 3) == 0)
        write_reg(IDX_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
      idle_en <= ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(3, 12)) begin
        n_smp = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
        repeat (n_smp) send_beat(OP_SAMPLE, pick_sample(), ELAPSED_W'($urandom));
        send_beat(OP_FINISH, SAMPLE_W'($urandom), pick_elapsed());
        sent += n_smp + 1;
        // Now and then the sender waits for every reading to come back.
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
    end
  endtask

  // Back-to-back full-scale windows at full gain and voltage, with no idling.
  task automatic test_full_scale_windows();
    idle_en <= 1'b0;
    wait_idle();
    write_reg(IDX_GAIN, CFG_DATA_W'(GAIN_MAX));
    write_reg(IDX_OFFSET_ERR, '0);
    write_reg(IDX_FLOOR, '0);
    write_reg(IDX_LINE_VOLTS, CFG_DATA_W'(VOLT_MAX));
    write_reg(IDX_ZERO_OFFSET, CFG_DATA_W'(512));
    repeat (FULL_SCALE_WINDOWS) begin
      send_beat(OP_SAMPLE, '0, ELAPSED_W'($urandom));
      send_beat(OP_SAMPLE, SAMPLE_MAX, ELAPSED_W'($urandom));
      send_beat(OP_FINISH, SAMPLE_W'($urandom), ELAPSED_MAX);
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.operation  <= OP_SAMPLE;
    in_bus.adc_sample <= '0;
    in_bus.elapsed_ms <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    idle_en           <= 1'b0;
    meter_cfg    = CFG_RESET;
    energy_armed = 1'b0;
    energy_acc   = 0;
    restart_window();
    repeat (5) @(posedge clk);
    rst_n   <= 1'b1;
    idle_en <= 1'b1;
    @(posedge clk);

    test_empty_window();
    test_deviation_extremes();
    test_offset_and_floor();
    test_unknown_index();
    test_span_across_offset();
    test_random_windows();
    test_full_scale_windows();

    // Drain, then give a late or stray beat time to show up.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop if the run hangs.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ppm_pkg.sv
rtl/ppm_if.sv
rtl/peak_to_peak_power_meter_unit.sv
tb/tb_peak_to_peak_power_meter_unit.sv
